@@ design/leaky_bucket_packet_shaper_unit_defines.svh @@
// Assertion macros used by the checker file of the leaky bucket shaper.
`ifndef LEAKY_BUCKET_PACKET_SHAPER_UNIT_DEFINES_SVH
`define LEAKY_BUCKET_PACKET_SHAPER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBPS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("leaky bucket shaper check failed");

// Consequent must hold in the cycle after the antecedent.
`define LBPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("leaky bucket shaper check failed");

`endif

@@ design/lbps_pkg.sv @@
// Types and constants of the leaky bucket packet shaper.
package lbps_pkg;

	localparam int SIZE_W      = 16;
	localparam int LIMIT_W     = 5;
	localparam int COUNT_OUT_W = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = 5;

	localparam logic [SIZE_W-1:0]    CAP_RESET   = 16'd6;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 5'd16;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd1;

	typedef struct packed {
		logic capture;
		logic enqueue;
		logic init_round;
		logic release_head;
		logic emit_empty;
		logic emit_release;
		logic last;
	} lbps_cmd_t;

	typedef struct packed {
		logic in_tick;
		logic out_free;
		logic queue_empty;
		logic head_fits;
		logic round_room;
	} lbps_status_t;

endpackage

@@ design/lbps_in_if.sv @@
// Input channel carrying enqueue and tick items.
interface lbps_in_if;
	import lbps_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [SIZE_W-1:0] packet_size;

	modport source (output valid, command, packet_size, input ready);
	modport sink (input valid, command, packet_size, output ready);
endinterface

@@ design/lbps_out_if.sv @@
// Output channel carrying enqueue and release results.
interface lbps_out_if;
	import lbps_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic                   released;
	logic [SIZE_W-1:0]      released_size;
	logic [SIZE_W-1:0]      space_left;
	logic [COUNT_OUT_W-1:0] queue_count;
	logic                   last;

	modport source (output valid, accepted, released, released_size, space_left,
		queue_count, last, input ready);
	modport sink (input valid, accepted, released, released_size, space_left,
		queue_count, last, output ready);
endinterface

@@ design/lbps_ctrl.sv @@
// Controller state machine sequencing enqueue and drain rounds.
module lbps_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lbps_pkg::lbps_status_t status,
	output lbps_pkg::lbps_cmd_t    cmd
);
	import lbps_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ENQ   = 3'd1;
	localparam logic [2:0] S_INIT  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_LOOK  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       more;

	assign more = !status.queue_empty && status.head_fits && status.round_room;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = status.in_tick ? S_INIT : S_ENQ;
				end
			end
			S_ENQ: begin
				if (status.out_free) begin
					cmd.enqueue = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_INIT: begin
				cmd.init_round = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (status.queue_empty || !status.head_fits) begin
					if (status.out_free) begin
						cmd.emit_empty = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cmd.release_head = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (status.out_free) begin
					cmd.emit_release = 1'b1;
					cmd.last = !more;
					if (more) begin
						cmd.release_head = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ design/lbps_datapath.sv @@
// Datapath with the size queue memory, bucket registers and the result register.
module lbps_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lbps_pkg::lbps_cmd_t                 cmd,
	output lbps_pkg::lbps_status_t              status,
	input  logic                                cfg_we,
	input  logic [lbps_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lbps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_command,
	input  logic [lbps_pkg::SIZE_W-1:0]         in_packet_size,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                out_accepted,
	output logic                                out_released,
	output logic [lbps_pkg::SIZE_W-1:0]         out_released_size,
	output logic [lbps_pkg::SIZE_W-1:0]         out_space_left,
	output logic [lbps_pkg::COUNT_OUT_W-1:0]    out_queue_count,
	output logic                                out_last
);
	import lbps_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [SIZE_W-1:0]    mem [QUEUE_DEPTH];
	logic [SIZE_W-1:0]    rdata_q;
	logic [SIZE_W-1:0]    cap_q;
	logic [LIMIT_W-1:0]   lim_q;
	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     tail_q;
	logic [PTR_W-1:0]     head_inc;
	logic [PTR_W-1:0]     tail_inc;
	logic [PTR_W-1:0]     head_d;
	logic [CNT_W-1:0]     count_q;
	logic [SIZE_W-1:0]    space_q;
	logic [SIZE_W-1:0]    pend_q;
	logic [RES_CNT_W-1:0] rounds_q;
	logic                 admit;
	logic [CMP_W-1:0]     count_ext;
	logic [CMP_W-1:0]     enq_count_ext;

	logic                   out_valid_q;
	logic                   accepted_q;
	logic                   released_q;
	logic [SIZE_W-1:0]      released_size_q;
	logic [SIZE_W-1:0]      space_left_q;
	logic [COUNT_OUT_W-1:0] queue_count_q;
	logic                   last_q;

	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
	assign head_d   = cmd.release_head ? head_inc : head_q;

	assign count_ext     = CMP_W'(count_q);
	assign admit         = (pend_q <= cap_q) && (count_ext < CMP_W'(lim_q))
		&& (count_q != CNT_FULL);
	assign enq_count_ext = CMP_W'(count_q + CNT_W'(admit));

	assign status.in_tick     = in_command;
	assign status.out_free    = !out_valid_q || out_ready;
	assign status.queue_empty = (count_q == '0);
	assign status.head_fits   = (rdata_q <= space_q);
	assign status.round_room  = (rounds_q < RES_CNT_W'(MAX_RESULTS));

	always_ff @(posedge clk) begin
		if (cmd.enqueue && admit) begin
			mem[tail_q] <= pend_q;
		end
		rdata_q <= mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			lim_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CAPACITY: cap_q <= cfg_data;
				REG_LIMIT:    lim_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			rounds_q <= '0;
		end else begin
			if (cmd.enqueue && admit) begin
				tail_q  <= tail_inc;
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.init_round) begin
				rounds_q <= '0;
			end
			if (cmd.release_head) begin
				head_q   <= head_inc;
				count_q  <= count_q - CNT_W'(1);
				rounds_q <= rounds_q + RES_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pend_q <= in_packet_size;
		end
		if (cmd.init_round) begin
			space_q <= cap_q;
		end
		if (cmd.release_head) begin
			pend_q  <= rdata_q;
			space_q <= space_q - rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.enqueue || cmd.emit_empty || cmd.emit_release) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enqueue) begin
			accepted_q      <= admit;
			released_q      <= 1'b0;
			released_size_q <= '0;
			space_left_q    <= '0;
			queue_count_q   <= enq_count_ext[COUNT_OUT_W-1:0];
			last_q          <= 1'b1;
		end else if (cmd.emit_empty) begin
			accepted_q      <= 1'b0;
			released_q      <= 1'b0;
			released_size_q <= '0;
			space_left_q    <= cap_q;
			queue_count_q   <= count_ext[COUNT_OUT_W-1:0];
			last_q          <= 1'b1;
		end else if (cmd.emit_release) begin
			accepted_q      <= 1'b0;
			released_q      <= 1'b1;
			released_size_q <= pend_q;
			space_left_q    <= space_q;
			queue_count_q   <= count_ext[COUNT_OUT_W-1:0];
			last_q          <= cmd.last;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_accepted      = accepted_q;
	assign out_released      = released_q;
	assign out_released_size = released_size_q;
	assign out_space_left    = space_left_q;
	assign out_queue_count   = queue_count_q;
	assign out_last          = last_q;
endmodule

@@ design/leaky_bucket_packet_shaper_unit.sv @@
// Top level of the leaky bucket packet shaper.
//   channel  direction  payload
//   in_ch    sink       command, packet_size
//   out_ch   source     accepted, released, released_size, space_left, queue_count, last
//   cfg      write      cfg_we, cfg_idx, cfg_data
// An enqueue loads its result register from the enqueue state that follows its transfer.
// A tick passes the init state to the check state, which loads the result of an empty round;
// otherwise the look state loads each release, paced by the registered read port of the queue.
// Reset clears the queue count, pointers, registers to their defaults and the result valid.
// A stalled output holds each result-loading state until the result register frees.
module leaky_bucket_packet_shaper_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lbps_in_if.sink                         in_ch,
	lbps_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [lbps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lbps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lbps_pkg::*;

	lbps_cmd_t    cmd;
	lbps_status_t status;

	lbps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	lbps_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_data          (cfg_data),
		.in_command        (in_ch.command),
		.in_packet_size    (in_ch.packet_size),
		.out_ready         (out_ch.ready),
		.out_valid         (out_ch.valid),
		.out_accepted      (out_ch.accepted),
		.out_released      (out_ch.released),
		.out_released_size (out_ch.released_size),
		.out_space_left    (out_ch.space_left),
		.out_queue_count   (out_ch.queue_count),
		.out_last          (out_ch.last)
	);
endmodule

@@ design/lbps_checker.sv @@
// Port level checks for the leaky bucket packet shaper and their binding.
`include "leaky_bucket_packet_shaper_unit_defines.svh"

module lbps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          out_accepted,
	input logic                          out_released,
	input logic [lbps_pkg::SIZE_W-1:0]   out_released_size,
	input logic                          out_last
);
	`LBPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_released_size) && $stable(out_last))
	`LBPS_ASSERT_SAME(a_enq_single, out_valid && out_accepted, out_last && !out_released)
	`LBPS_ASSERT_SAME(a_size_zero, out_valid && !out_released, out_released_size == '0)
	`LBPS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
endmodule

bind leaky_bucket_packet_shaper_unit lbps_checker u_lbps_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_ch.valid),
	.in_ready          (in_ch.ready),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.out_accepted      (out_ch.accepted),
	.out_released      (out_ch.released),
	.out_released_size (out_ch.released_size),
	.out_last          (out_ch.last)
);
